>>> src/tok_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers of the character tokenizer
package tok_pkg;

  // text length limit and the derived position cap
  localparam int unsigned MAX_TEXT = 65536;
  localparam int POS_W = 16;
  localparam int LEN_W = 16;
  localparam int CH_W  = 8;
  localparam logic [POS_W-1:0] POS_CAP =
    ((MAX_TEXT - 1) > 65535) ? {POS_W{1'b1}} : POS_W'(MAX_TEXT - 1);
  localparam logic [LEN_W-1:0] LEN_CAP = {LEN_W{1'b1}};

  // depth of the queue between front and back
  localparam int QDEPTH = 2;

  // character codes
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_E     = 8'h65;

  // byte classes seen by the lexer
  typedef enum logic [2:0] {
    CLS_WORD     = 3'd0,
    CLS_SPACE    = 3'd1,
    CLS_QUOTE    = 3'd2,
    CLS_DIGIT    = 3'd3,
    CLS_DOT      = 3'd4,
    CLS_LETTER_E = 3'd5,
    CLS_PUNCT    = 3'd6
  } tok_cls_t;

  // one classified byte
  typedef struct packed {
    logic [POS_W-1:0] pos;
    tok_cls_t         cls;
    logic             last;
  } tok_item_t;

  // one token beat
  typedef struct packed {
    logic [POS_W-1:0] tok_start;
    logic [LEN_W-1:0] tok_len;
    logic             run_end;
  } tok_result_t;

  // queue status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } tok_q_stat_t;

  // position increment that sticks at the cap
  function automatic logic [POS_W-1:0] sat_pos_inc(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] r;
    if (p >= POS_CAP) r = POS_CAP;
    else r = p + POS_W'(1);
    return r;
  endfunction

endpackage

>>> src/tok_queue.sv
`timescale 1ns / 1ps
// short queue of classified bytes between front and back
module tok_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr,
  input  tok_pkg::tok_item_t  wr_item,
  input  logic                rd,
  output tok_pkg::tok_item_t  rd_item,
  output tok_pkg::tok_q_stat_t stat
);
  import tok_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  tok_item_t        mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (wr && !rd) count_nxt = count_r + CNT_W'(1);
    else if (!wr && rd) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr) mem_r[wr_ptr_r] <= wr_item;
  end

  assign rd_item    = mem_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(QDEPTH));

`ifndef NO_ASSERTIONS
  a_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr |-> (count_r != CNT_W'(QDEPTH)) || rd)
    else $error("byte queue written while full");
  a_q_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd |-> count_r != '0)
    else $error("byte queue read while empty");
  a_q_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QDEPTH))
    else $error("byte queue count out of range");
`endif

endmodule

>>> src/tok_front.sv
`timescale 1ns / 1ps
// input side: position counter and byte classification
module tok_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [7:0]           in_ch,
  input  logic                 in_final_byte,
  input  tok_pkg::tok_q_stat_t q_stat,
  output logic                 q_push,
  output tok_pkg::tok_item_t   q_item
);
  import tok_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  tok_cls_t         cls;
  logic             is_punct;

  // punctuation ranges of printable ascii
  assign is_punct = (in_ch >= 8'd33  && in_ch <= 8'd47)  ||
                    (in_ch >= 8'd58  && in_ch <= 8'd64)  ||
                    (in_ch >= 8'd91  && in_ch <= 8'd96)  ||
                    (in_ch >= 8'd123 && in_ch <= 8'd126);

  // byte class
  always_comb begin
    if (in_ch == CH_QUOTE) cls = CLS_QUOTE;
    else if (in_ch == CH_SPACE) cls = CLS_SPACE;
    else if (in_ch >= CH_ZERO && in_ch <= CH_NINE) cls = CLS_DIGIT;
    else if (in_ch == CH_DOT) cls = CLS_DOT;
    else if (in_ch == CH_E) cls = CLS_LETTER_E;
    else if (is_punct) cls = CLS_PUNCT;
    else cls = CLS_WORD;
  end

  assign q_push      = push && !q_stat.full;
  assign q_item.pos  = pos_r;
  assign q_item.cls  = cls;
  assign q_item.last = in_final_byte;

  // position of the next byte, back to zero after the last byte of a text
  always_comb begin
    pos_nxt = pos_r;
    if (q_push) pos_nxt = in_final_byte ? '0 : sat_pos_inc(pos_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

>>> src/tok_back.sv
`timescale 1ns / 1ps
// lexer side: mode state, token forming and result buffer
module tok_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tok_pkg::tok_item_t    q_item,
  input  tok_pkg::tok_q_stat_t  q_stat,
  output logic                  q_pop,
  input  logic                  pop,
  output logic                  empty,
  output tok_pkg::tok_result_t  res_out
);
  import tok_pkg::*;

  typedef enum logic [1:0] {
    MODE_DEFAULT = 2'd0,
    MODE_NUMBER  = 2'd1,
    MODE_STRING  = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t            mode;
    logic [POS_W-1:0] ps;
    logic [LEN_W-1:0] pl;
    logic             emit;
    logic [POS_W-1:0] e_start;
    logic [LEN_W-1:0] e_len;
    logic             again;
  } pass_t;

  // one look at the byte in the current mode
  function automatic pass_t pass_f(input tok_cls_t cls, input logic [POS_W-1:0] pos,
                                   input mode_t mode, input logic [POS_W-1:0] ps,
                                   input logic [LEN_W-1:0] pl);
    pass_t r;
    logic  digit;
    logic  numeric;
    logic  space;
    logic  punct;
    r.mode    = mode;
    r.ps      = ps;
    r.pl      = pl;
    r.emit    = 1'b0;
    r.e_start = ps;
    r.e_len   = pl;
    r.again   = 1'b0;
    digit   = (cls == CLS_DIGIT);
    numeric = digit || (cls == CLS_DOT) || (cls == CLS_LETTER_E);
    space   = (cls == CLS_SPACE);
    punct   = (cls == CLS_PUNCT) || (cls == CLS_DOT);
    if (cls == CLS_QUOTE) begin
      if (mode == MODE_STRING) begin
        // closing quote, empty string still gives a token
        r.mode = MODE_DEFAULT;
        r.emit = 1'b1;
        r.pl   = '0;
      end else if (mode == MODE_NUMBER) begin
        r.emit  = 1'b1;
        r.pl    = '0;
        r.mode  = MODE_DEFAULT;
        r.again = 1'b1;
      end else begin
        // opening quote ends any word
        r.emit = (pl != '0);
        r.mode = MODE_STRING;
        r.pl   = '0;
        r.ps   = sat_pos_inc(pos);
      end
    end else if (!numeric && mode == MODE_NUMBER) begin
      // number ends; a space is eaten, anything else is looked at again
      r.emit  = 1'b1;
      r.pl    = '0;
      r.mode  = MODE_DEFAULT;
      r.again = !space;
    end else begin
      if (digit && mode != MODE_NUMBER && mode != MODE_STRING) r.mode = MODE_NUMBER;
      if (r.mode != MODE_NUMBER && r.mode != MODE_STRING && (space || punct)) begin
        if (space) begin
          r.emit = (pl != '0);
          r.pl   = '0;
        end else if (pl != '0) begin
          r.emit  = 1'b1;
          r.pl    = '0;
          r.again = 1'b1;
        end else begin
          r.emit    = 1'b1;
          r.e_start = pos;
          r.e_len   = LEN_W'(1);
        end
      end else begin
        if (pl == '0) r.ps = pos;
        if (pl != LEN_CAP) r.pl = pl + LEN_W'(1);
      end
    end
    return r;
  endfunction

  mode_t            mode_r, mode_nxt;
  logic [POS_W-1:0] ps_r, ps_nxt;
  logic [LEN_W-1:0] pl_r, pl_nxt;
  logic             phase_r, phase_nxt;
  logic [1:0]       out_cnt_r, out_cnt_nxt;
  tok_result_t      head_r, head_nxt;
  tok_result_t      tail_r, tail_nxt;

  pass_t       p1;
  pass_t       p2;
  pass_t       s2;
  logic        p2_emit;
  logic        fin_emit;
  logic [1:0]  n_res;
  tok_result_t res0;
  tok_result_t res1;
  tok_result_t wr_res;
  logic        head_ok;
  logic        can_wr;
  logic        wr;
  logic        commit;
  logic        pop_fire;
  logic [1:0]  cnt_after;

  // both passes and the end-of-text flush for the head byte
  always_comb begin
    p1 = pass_f(q_item.cls, q_item.pos, mode_r, ps_r, pl_r);
    p2 = pass_f(q_item.cls, q_item.pos, p1.mode, p1.ps, p1.pl);
    if (p1.again) begin
      s2      = p2;
      p2_emit = p2.emit;
    end else begin
      s2      = p1;
      p2_emit = 1'b0;
    end
    fin_emit = q_item.last && (s2.pl != '0);
  end

  // pack up to two token beats in order
  always_comb begin
    n_res = 2'd0;
    res0  = '0;
    res1  = '0;
    if (p1.emit) begin
      res0.tok_start = p1.e_start;
      res0.tok_len   = p1.e_len;
      n_res          = 2'd1;
    end
    if (p2_emit) begin
      if (n_res == 2'd0) begin
        res0.tok_start = p2.e_start;
        res0.tok_len   = p2.e_len;
      end else begin
        res1.tok_start = p2.e_start;
        res1.tok_len   = p2.e_len;
      end
      n_res = n_res + 2'd1;
    end
    if (fin_emit) begin
      if (n_res == 2'd0) begin
        res0.tok_start = s2.ps;
        res0.tok_len   = s2.pl;
        n_res          = 2'd1;
      end else if (n_res == 2'd1) begin
        res1.tok_start = s2.ps;
        res1.tok_len   = s2.pl;
        n_res          = 2'd2;
      end
    end
    res0.run_end = (n_res == 2'd1);
    res1.run_end = 1'b1;
  end

  // handshake between head byte and result buffer
  assign head_ok  = !q_stat.empty;
  assign can_wr   = (out_cnt_r != 2'd2);
  assign wr       = head_ok && (n_res != 2'd0) && can_wr;
  assign commit   = head_ok && ((n_res == 2'd0) ||
                    (can_wr && (phase_r || n_res == 2'd1)));
  assign q_pop    = commit;
  assign wr_res   = phase_r ? res1 : res0;
  assign pop_fire = pop && (out_cnt_r != 2'd0);
  assign cnt_after = out_cnt_r - {1'b0, pop_fire};

  // next lexer state, result buffer shifting
  always_comb begin
    mode_nxt    = mode_r;
    ps_nxt      = ps_r;
    pl_nxt      = pl_r;
    phase_nxt   = phase_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    out_cnt_nxt = cnt_after + {1'b0, wr};
    if (commit) begin
      phase_nxt = 1'b0;
      if (q_item.last) begin
        mode_nxt = MODE_DEFAULT;
        ps_nxt   = '0;
        pl_nxt   = '0;
      end else begin
        mode_nxt = s2.mode;
        ps_nxt   = s2.ps;
        pl_nxt   = s2.pl;
      end
    end else if (wr) begin
      phase_nxt = 1'b1;
    end
    if (pop_fire) head_nxt = tail_r;
    if (wr) begin
      if (cnt_after == 2'd0) head_nxt = wr_res;
      else tail_nxt = wr_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_DEFAULT;
      ps_r      <= '0;
      pl_r      <= '0;
      phase_r   <= 1'b0;
      out_cnt_r <= 2'd0;
    end else begin
      mode_r    <= mode_nxt;
      ps_r      <= ps_nxt;
      pl_r      <= pl_nxt;
      phase_r   <= phase_nxt;
      out_cnt_r <= out_cnt_nxt;
    end
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  assign empty   = (out_cnt_r == 2'd0);
  assign res_out = head_r;

`ifndef NO_ASSERTIONS
  a_phase_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> !q_stat.empty)
    else $error("second beat pending without a head byte");
  a_phase_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r && !q_pop) |=> phase_r)
    else $error("second beat dropped before its byte was retired");
  a_out_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_cnt_r != 2'd3)
    else $error("result buffer count out of range");
`endif

endmodule

>>> src/three_mode_char_tokenizer.sv
`timescale 1ns / 1ps
// top level of the three-mode character tokenizer
//
//  channel  | handshake        | beat
//  ---------+------------------+-------------------------------------------
//  input    | push / full      | in_ch, in_final_byte
//  result   | empty / pop      | out_tok_start, out_tok_len, out_run_end
//
// one byte per cycle sustained while the result buffer has room; a byte that yields two tokens
// holds the lexer until both are written, since the result buffer has a single write port.
// a byte passes through the byte queue, and its token is registered in the result buffer before it shows.
// synchronous active-low reset empties both queues and sets position to zero.
// a stalled result side backs up through the byte queue to full.
module three_mode_char_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_ch,
  input  logic        in_final_byte,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_tok_start,
  output logic [15:0] out_tok_len,
  output logic        out_run_end
);
  import tok_pkg::*;

  tok_q_stat_t q_stat;
  tok_item_t   wr_item;
  tok_item_t   rd_item;
  tok_result_t res;
  logic        q_push;
  logic        q_pop;

  // classification and position
  tok_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .in_ch         (in_ch),
    .in_final_byte (in_final_byte),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_item        (wr_item)
  );

  // decoupling queue
  tok_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_push),
    .wr_item (wr_item),
    .rd      (q_pop),
    .rd_item (rd_item),
    .stat    (q_stat)
  );

  // lexer and result buffer
  tok_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (rd_item),
    .q_stat  (q_stat),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .res_out (res)
  );

  assign full          = q_stat.full;
  assign out_tok_start = res.tok_start;
  assign out_tok_len   = res.tok_len;
  assign out_run_end   = res.run_end;

endmodule

>>> tb/three_mode_char_tokenizer_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the three-mode character tokenizer
module three_mode_char_tokenizer_tb;
  import tok_pkg::*;

  // run length guard, well above the slowest legal run
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_BYTES  = 1500;
  localparam int LONG_WORD_LEN = 200;
  localparam int HOLDOFF_AT    = 150;
  localparam int HOLDOFF_LEN   = 400;
  localparam int PRINT_CAP     = 50;

  // lexer modes of the predictor
  typedef enum logic [1:0] {
    LX_DEFAULT = 2'd0,
    LX_NUMBER  = 2'd1,
    LX_STRING  = 2'd2
  } lex_mode_t;

  // one byte waiting to be sent; steady bytes are sent without gaps
  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       steady;
  } text_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_ch = 8'h00;
  logic        in_final_byte = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [15:0] out_tok_start;
  logic [15:0] out_tok_len;
  logic        out_run_end;

  // predictor state
  lex_mode_t   lx_mode;
  logic [15:0] lx_pos;
  logic [15:0] lx_tok_start;
  logic [15:0] lx_tok_len;
  tok_result_t step_toks[$];
  tok_result_t tokens_due[$];

  // stimulus and handshake bookkeeping
  text_byte_t  pending_bytes[$];
  text_byte_t  nxt_byte;
  logic [7:0]  text_buf[$];
  int          burst_left = 0;
  int          gap_left = 0;
  logic [7:0]  pop_pattern = 8'hFF;
  int          pattern_age = 0;
  int          holdoff_left = 0;
  bit          holdoff_done = 1'b0;
  int          tokens_seen = 0;
  int          mismatches = 0;
  int          cycle_count = 0;

  three_mode_char_tokenizer dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_ch         (in_ch),
    .in_final_byte (in_final_byte),
    .empty         (empty),
    .pop           (pop),
    .out_tok_start (out_tok_start),
    .out_tok_len   (out_tok_len),
    .out_run_end   (out_run_end)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // position step that sticks at the cap
  function automatic logic [15:0] pos_after(input logic [15:0] p);
    return (p >= POS_CAP) ? POS_CAP : p + 16'd1;
  endfunction

  // punctuation bytes that stand as tokens of their own
  function automatic bit is_mark(input logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic lex_reset();
    lx_mode      = LX_DEFAULT;
    lx_pos       = 16'd0;
    lx_tok_start = 16'd0;
    lx_tok_len   = 16'd0;
    tokens_due.delete();
  endtask

  // at most two tokens per byte
  task automatic note_token(input logic [15:0] s, input logic [15:0] l);
    tok_result_t t;
    if (step_toks.size() < 2) begin
      t.tok_start = s;
      t.tok_len   = l;
      t.run_end   = 1'b0;
      step_toks.push_back(t);
    end
  endtask

  task automatic close_pending();
    note_token(lx_tok_start, lx_tok_len);
    lx_tok_len = 16'd0;
  endtask

  // one pass over a byte; again is set when the byte must be seen once more
  task automatic lex_pass(input logic [7:0] c, input logic [15:0] pos, output bit again);
    bit digit;
    bit numeric;
    bit handled;
    digit   = is_digit(c);
    numeric = digit || c == CH_DOT || c == CH_E;
    again   = 1'b0;
    handled = 1'b0;
    if (c == CH_QUOTE) begin
      // quote closes a string, ends a number, or opens a string
      if (lx_mode == LX_STRING) begin
        lx_mode = LX_DEFAULT;
        close_pending();
      end else if (lx_mode == LX_NUMBER) begin
        close_pending();
        lx_mode = LX_DEFAULT;
        again = 1'b1;
      end else begin
        if (lx_tok_len != 16'd0) close_pending();
        lx_mode      = LX_STRING;
        lx_tok_len   = 16'd0;
        lx_tok_start = pos_after(pos);
      end
    end else begin
      // number entry and number exit
      if (digit && lx_mode != LX_NUMBER && lx_mode != LX_STRING) begin
        lx_mode = LX_NUMBER;
      end else if (!numeric && lx_mode == LX_NUMBER) begin
        close_pending();
        lx_mode = LX_DEFAULT;
        again   = (c != CH_SPACE);
        handled = 1'b1;
      end
      if (!handled) begin
        if (lx_mode != LX_NUMBER && lx_mode != LX_STRING &&
            (c == CH_SPACE || is_mark(c))) begin
          // separators and single-byte punctuation
          if (c == CH_SPACE) begin
            if (lx_tok_len != 16'd0) close_pending();
          end else if (lx_tok_len != 16'd0) begin
            close_pending();
            again = 1'b1;
          end else begin
            note_token(pos, 16'd1);
          end
        end else begin
          // byte extends the buffered token
          if (lx_tok_len == 16'd0) lx_tok_start = pos;
          if (lx_tok_len < LEN_CAP) lx_tok_len = lx_tok_len + 16'd1;
        end
      end
    end
  endtask

  // predicts the tokens of one accepted byte and queues them
  task automatic take_byte(input logic [7:0] c, input logic last);
    logic [15:0] pos;
    bit          again;
    tok_result_t t;
    step_toks.delete();
    pos = lx_pos;
    lex_pass(c, pos, again);
    if (again) lex_pass(c, pos, again);
    if (last) begin
      if (lx_tok_len != 16'd0) close_pending();
      lx_mode      = LX_DEFAULT;
      lx_pos       = 16'd0;
      lx_tok_start = 16'd0;
      lx_tok_len   = 16'd0;
    end else begin
      lx_pos = pos_after(pos);
    end
    if (step_toks.size() > 0) begin
      t = step_toks.pop_back();
      t.run_end = 1'b1;
      step_toks.push_back(t);
    end
    foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
    if (mismatches < PRINT_CAP)
      $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $time);
    mismatches++;
  endtask

  // compares one token beat with the oldest prediction
  task automatic check_token(input logic [15:0] s, input logic [15:0] l, input logic r);
    tok_result_t want;
    if (tokens_due.size() == 0) begin
      report_mismatch("token with none due, start", 16'd0, s);
    end else begin
      want = tokens_due.pop_front();
      if (want.tok_start !== s) report_mismatch("tok_start", want.tok_start, s);
      if (want.tok_len !== l) report_mismatch("tok_len", want.tok_len, l);
      if (want.run_end !== r) report_mismatch("run_end", want.run_end, r);
    end
  endtask

  // stimulus helpers
  task automatic queue_byte(input logic [7:0] c, input logic last, input logic steady);
    text_byte_t b;
    b.ch     = c;
    b.last   = last;
    b.steady = steady;
    pending_bytes.push_back(b);
  endtask

  task automatic queue_str(input string s, input bit ends);
    for (int i = 0; i < s.len(); i++)
      queue_byte(s[i], ends && (i == s.len() - 1), 1'b0);
  endtask

  function automatic logic [7:0] word_byte();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) begin
      c = 8'($urandom_range(97, 122));
    end else begin
      c = 8'($urandom);
      while (is_mark(c) || c == CH_SPACE || is_digit(c)) c = 8'($urandom);
    end
    return c;
  endfunction

  function automatic logic [7:0] number_byte();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0: c = CH_DOT;
      1: c = CH_E;
      default: c = 8'($urandom_range(CH_ZERO, CH_NINE));
    endcase
    return c;
  endfunction

  function automatic logic [7:0] mark_byte();
    logic [7:0] c;
    c = CH_QUOTE;
    while (c == CH_QUOTE) begin
      case ($urandom_range(0, 3))
        0: c = 8'($urandom_range(33, 47));
        1: c = 8'($urandom_range(58, 64));
        2: c = 8'($urandom_range(91, 96));
        default: c = 8'($urandom_range(123, 126));
      endcase
    end
    return c;
  endfunction

  // builds one well-formed text of mixed tokens in text_buf
  task automatic build_text();
    int         n_toks;
    int         n;
    logic [7:0] c;
    text_buf.delete();
    n_toks = $urandom_range(1, 10);
    for (int k = 0; k < n_toks; k++) begin
      case ($urandom_range(0, 7))
        0, 1, 2: begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) text_buf.push_back(word_byte());
        end
        3, 4: begin
          text_buf.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
          n = $urandom_range(0, 5);
          for (int i = 0; i < n; i++) text_buf.push_back(number_byte());
        end
        5: begin
          text_buf.push_back(CH_QUOTE);
          n = $urandom_range(0, 5);
          for (int i = 0; i < n; i++) begin
            c = 8'($urandom);
            while (c == CH_QUOTE) c = 8'($urandom);
            text_buf.push_back(c);
          end
          if ($urandom_range(0, 4) != 0) text_buf.push_back(CH_QUOTE);
        end
        6: text_buf.push_back(mark_byte());
        default: begin
          n = $urandom_range(1, 2);
          for (int i = 0; i < n; i++) text_buf.push_back(CH_SPACE);
        end
      endcase
      if ($urandom_range(0, 1) == 0) text_buf.push_back(CH_SPACE);
    end
  endtask

  // reset, stimulus, drain and verdict
  initial begin
    int sent_random;
    int n;
    sent_random = 0;
    @(posedge clk);
    @(posedge clk);
    rst_n <= 1'b1;

    // directed: byte extremes, number endings, strings and the flush at the last byte
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_str(" 7.e3,9 ~4\"a !\"w\"\"z\"", 1'b1);
    queue_str("5", 1'b1);
    queue_str("\"", 1'b1);

    // long word sent back to back, then punctuation and a string left open
    for (int i = 0; i < LONG_WORD_LEN; i++)
      queue_byte(8'($urandom_range(97, 122)), 1'b0, 1'b1);
    queue_byte(8'h2C, 1'b0, 1'b1);
    queue_byte(8'h78, 1'b0, 1'b1);
    queue_byte(8'h78, 1'b0, 1'b1);
    queue_byte(CH_QUOTE, 1'b1, 1'b1);

    // random: mostly well-formed texts, some raw noise
    while (sent_random < RANDOM_BYTES) begin
      if ($urandom_range(0, 99) < 85) begin
        build_text();
        foreach (text_buf[i])
          queue_byte(text_buf[i], i == text_buf.size() - 1, 1'b0);
        sent_random += text_buf.size();
      end else begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
          queue_byte(8'($urandom), $urandom_range(0, 7) == 0, 1'b0);
        sent_random += n;
      end
    end

    // drain
    while (pending_bytes.size() != 0 || push) @(posedge clk);
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // byte driver: bursts of random length with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      push          <= 1'b0;
      in_ch         <= 8'h00;
      in_final_byte <= 1'b0;
      lex_reset();
    end else begin
      if (push && !full) take_byte(in_ch, in_final_byte);
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          nxt_byte = pending_bytes.pop_front();
          push          <= 1'b1;
          in_ch         <= nxt_byte.ch;
          in_final_byte <= nxt_byte.last;
          if (!nxt_byte.steady) begin
            if (burst_left == 0) burst_left = $urandom_range(1, 40);
            burst_left--;
            if (burst_left == 0) gap_left = $urandom_range(0, 8);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // token monitor: rotating stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        check_token(out_tok_start, out_tok_len, out_run_end);
        tokens_seen++;
      end
      if (!holdoff_done && tokens_seen >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_LEN;
      end
      pattern_age++;
      if (pattern_age == 96) begin
        pattern_age = 0;
        pop_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end else begin
        pop_pattern = {pop_pattern[6:0], pop_pattern[7]};
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        pop <= 1'b0;
      end else begin
        pop <= pop_pattern[0];
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tokens outstanding", cycle_count,
               tokens_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
